// ----- hdl/msca_pkg.sv -----
`timescale 1ns / 1ps
package msca_pkg;
    localparam int MaxClusters = 16;
    localparam int NodeCount = 1024;
    localparam int MaxSetSize = 64;
    localparam int SlotW = 4;
    localparam int NodeW = 10;
    localparam int ListAw = 6;
    localparam int SizeW = 7;
    localparam int CostW = 32;
    localparam int MemAw = SlotW + NodeW;
    localparam int CListAw = SlotW + ListAw;

    localparam logic [1:0] CfgClusters  = 2'd0;
    localparam logic [1:0] CfgThreshold = 2'd1;
    localparam logic [1:0] CfgMaxVolume = 2'd2;

    typedef struct packed {
        logic [9:0]  median_node;
        logic [31:0] solution_cost;
        logic        last_median;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        cluster_index;
        logic signed [7:0] distance;
        logic              opened_slot;
        logic              center_replaced;
        logic              intensify_due;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;    // one step of the membership clearing pass
        logic take_median;   // store median, issue membership reads
        logic tally;         // membership read data is valid, bump tallies
        logic scan_step;     // examine one slot for the nearest center
        logic decide;        // compute chosen slot and outcome
        logic erase_step;    // clear one old center member
        logic write_step;    // write one incoming member
        logic finish;        // commit slot state, build result
    } msca_cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic clear_done;
        logic last_item;
        logic scan_done;
        logic do_load;       // decision requires rewriting the center
        logic no_result;
        logic erase_done;
        logic write_done;
    } msca_sts_t;
endpackage

// ----- hdl/median_set_cluster_assigner_unit.sv -----
`timescale 1ns / 1ps
// Median-set cluster assigner. Each median transfer reads the membership RAMs of all
// 16 slots, then bumps the miss tally of each slot that does not hold the node if the
// node was stored. After the last median the block scans one slot per cycle over the
// configured slot count for the nearest center and the lowest free slot, then makes
// the decision. When a center is created or replaced, the old members are erased from
// that slot's membership RAM and the new ones written into it, one member per step,
// each pass taking an extra step for the list read; otherwise both are skipped.
// The slot state is then committed and, unless no slot was chosen, the result is
// presented. Medians of the next solution are accepted while a result waits, but the
// next commit holds until that result is taken. After reset a clearing pass runs over
// all 1024 entries of the membership RAMs before the first transfer is accepted.
// Configuration should be written only while no solution is in flight.
module median_set_cluster_assigner_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  msca_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output msca_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    logic [4:0] clusters_reg;
    logic [6:0] threshold_reg;
    logic [7:0] max_volume_reg;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clusters_reg <= 5'd16;
            threshold_reg <= 7'd1;
            max_volume_reg <= 8'd5;
        end else if (cfg_we) begin
            if (cfg_index == msca_pkg::CfgClusters) clusters_reg <= cfg_data[4:0];
            if (cfg_index == msca_pkg::CfgThreshold) threshold_reg <= cfg_data[6:0];
            if (cfg_index == msca_pkg::CfgMaxVolume) max_volume_reg <= cfg_data;
        end
    end

    msca_pkg::msca_cmd_t cmd;
    msca_pkg::msca_sts_t sts;

    msca_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready),
        .cmd(cmd), .sts(sts)
    );

    msca_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .sts(sts), .in_item(s_data),
        .cfg_clusters(clusters_reg), .cfg_threshold(threshold_reg),
        .cfg_max_volume(max_volume_reg), .result(m_data)
    );

    // A result never appears while the input side is mid-tally.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tally |-> !cmd.finish) else $error("tally and finish overlap");
    // The result holds until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data)) else $error("result changed while stalled");
    // Accepting a median always triggers a tally next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> cmd.tally) else $error("missing tally");
endmodule

// ----- hdl/msca_ram.sv -----
`timescale 1ns / 1ps
module msca_ram #(
    parameter int Width = 1,
    parameter int Depth = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/msca_datapath.sv -----
`timescale 1ns / 1ps
module msca_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  msca_pkg::msca_cmd_t  cmd,
    output msca_pkg::msca_sts_t  sts,
    input  msca_pkg::in_item_t   in_item,
    input  logic [4:0]           cfg_clusters,
    input  logic [6:0]           cfg_threshold,
    input  logic [7:0]           cfg_max_volume,
    output msca_pkg::out_item_t  result
);
    localparam int Mc = msca_pkg::MaxClusters;
    localparam int Mw = msca_pkg::MemAw;

    // Membership: one RAM per slot so all slots are read in the same cycle.
    logic [Mc-1:0] mem_rd;
    logic [Mc-1:0] mem_we;
    logic [msca_pkg::NodeW-1:0] mem_waddr;
    logic mem_wdata;

    logic [msca_pkg::NodeW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [msca_pkg::SizeW-1:0] in_size_reg;
    logic [msca_pkg::SizeW-1:0] miss_reg [Mc];
    logic [Mc-1:0] valid_reg;
    logic [7:0] vol_reg [Mc];
    logic [msca_pkg::SizeW-1:0] csize_reg [Mc];
    logic [msca_pkg::CostW-1:0] ccost_reg [Mc];
    logic taking_reg;
    logic [msca_pkg::CostW-1:0] cost_reg;
    logic last_reg;

    // Decision registers.
    logic [msca_pkg::SlotW-1:0] chosen_reg;
    logic create_reg, replace_reg, none_reg;
    logic [msca_pkg::SizeW-1:0] best_reg;
    logic [msca_pkg::SizeW-1:0] step_reg;

    // Slot scan registers: nearest valid center and lowest free slot so far.
    logic [4:0] scan_reg;
    logic near_f_reg, free_f_reg;
    logic [msca_pkg::SlotW-1:0] near_idx_reg, free_slot_reg;
    logic [msca_pkg::SizeW-1:0] near_d_reg;
    logic [msca_pkg::CostW-1:0] near_cost_reg;

    logic node_ok;
    assign node_ok = (in_size_reg < msca_pkg::SizeW'(msca_pkg::MaxSetSize));

    // Lists: incoming list and center lists in RAM.
    logic [msca_pkg::NodeW-1:0] inl_rdata, cl_rdata;
    logic [msca_pkg::ListAw-1:0] step_addr;
    assign step_addr = step_reg[msca_pkg::ListAw-1:0];

    msca_ram #(.Width(msca_pkg::NodeW), .Depth(msca_pkg::MaxSetSize)) u_inl (
        .aclk(aclk), .we(cmd.take_median && node_ok),
        .waddr(in_size_reg[msca_pkg::ListAw-1:0]), .wdata(in_item.median_node),
        .raddr(step_addr), .rdata(inl_rdata)
    );

    // Erase/write sequencing: step_reg issues the read, data is used next cycle
    // at the address held in pend_addr_reg.
    logic pend_reg;
    logic [msca_pkg::ListAw-1:0] pend_addr_reg;
    logic cl_we;
    assign cl_we = cmd.write_step && pend_reg;

    msca_ram #(.Width(msca_pkg::NodeW), .Depth(Mc * msca_pkg::MaxSetSize)) u_cl (
        .aclk(aclk), .we(cl_we), .waddr({chosen_reg, pend_addr_reg}), .wdata(inl_rdata),
        .raddr({chosen_reg, step_addr}), .rdata(cl_rdata)
    );

    always_comb begin
        mem_we = '0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = 1'b0;
        if (cmd.clear_step) begin
            mem_we = '1;
        end else if (pend_reg && cmd.erase_step) begin
            mem_we[chosen_reg] = 1'b1;
            mem_waddr = cl_rdata;
        end else if (pend_reg && cmd.write_step) begin
            mem_we[chosen_reg] = 1'b1;
            mem_waddr = inl_rdata;
            mem_wdata = 1'b1;
        end
    end

    for (genvar g = 0; g < Mc; g++) begin : g_mem
        msca_ram #(.Width(1), .Depth(msca_pkg::NodeCount)) u_mem (
            .aclk(aclk), .we(mem_we[g]), .waddr(mem_waddr), .wdata(mem_wdata),
            .raddr(in_item.median_node), .rdata(mem_rd[g])
        );
    end

    assign clr_cnt_next = clr_cnt_reg + 1'b1;

    // Effective slot count and volume limit.
    logic [4:0] g_eff;
    logic [7:0] mv_eff;
    always_comb begin
        g_eff = (cfg_clusters == 5'd0) ? 5'd1 :
                (cfg_clusters > 5'(Mc)) ? 5'(Mc) : cfg_clusters;
        mv_eff = (cfg_max_volume == 8'd0) ? 8'd1 : cfg_max_volume;
    end

    // One slot is examined per scan step.
    logic [msca_pkg::SlotW-1:0] scan_slot;
    assign scan_slot = scan_reg[msca_pkg::SlotW-1:0];

    logic scan_better;
    assign scan_better = !near_f_reg || miss_reg[scan_slot] < near_d_reg ||
                         (miss_reg[scan_slot] == near_d_reg &&
                          ccost_reg[scan_slot] < near_cost_reg);

    logic dec_create;
    assign dec_create = free_f_reg && (!near_f_reg || near_d_reg > cfg_threshold);

    logic [7:0] vol_up;
    assign vol_up = create_reg ? 8'd1 :
                    (vol_reg[chosen_reg] == 8'd255) ? 8'd255 : vol_reg[chosen_reg] + 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            in_size_reg <= '0;
            valid_reg <= '0;
            taking_reg <= 1'b0;
            pend_reg <= 1'b0;
            step_reg <= '0;
            scan_reg <= '0;
            near_f_reg <= 1'b0;
            free_f_reg <= 1'b0;
            for (int j = 0; j < Mc; j++) begin
                miss_reg[j] <= '0;
                vol_reg[j] <= '0;
                csize_reg[j] <= '0;
            end
        end else begin
            if (cmd.clear_step) clr_cnt_reg <= clr_cnt_next;
            taking_reg <= cmd.take_median && node_ok;
            if (cmd.take_median) begin
                cost_reg <= in_item.solution_cost;
                last_reg <= in_item.last_median;
                if (node_ok) in_size_reg <= in_size_reg + 1'b1;
            end
            if (cmd.tally && taking_reg) begin
                for (int j = 0; j < Mc; j++) begin
                    if (!mem_rd[j]) miss_reg[j] <= miss_reg[j] + 1'b1;
                end
            end
            if (cmd.scan_step) begin
                if (!valid_reg[scan_slot]) begin
                    if (!free_f_reg) begin
                        free_f_reg <= 1'b1;
                        free_slot_reg <= scan_slot;
                    end
                end else if (scan_better) begin
                    near_f_reg <= 1'b1;
                    near_idx_reg <= scan_slot;
                    near_d_reg <= miss_reg[scan_slot];
                    near_cost_reg <= ccost_reg[scan_slot];
                end
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.decide) begin
                create_reg <= dec_create;
                none_reg <= !dec_create && !near_f_reg;
                chosen_reg <= dec_create ? free_slot_reg : near_idx_reg;
                best_reg <= near_d_reg;
                replace_reg <= !dec_create && near_f_reg && cost_reg < near_cost_reg;
                step_reg <= '0;
                pend_reg <= 1'b0;
            end
            if (cmd.erase_step || cmd.write_step) begin
                pend_reg <= !(cmd.erase_step ? sts.erase_done : sts.write_done);
                step_reg <= (cmd.erase_step && sts.erase_done) ? '0 : step_reg + 1'b1;
                pend_addr_reg <= step_addr;
            end
            if (cmd.finish) begin
                if (!none_reg) begin
                    valid_reg[chosen_reg] <= 1'b1;
                    vol_reg[chosen_reg] <= (vol_up >= mv_eff) ? 8'd0 : vol_up;
                    if (create_reg || replace_reg) begin
                        csize_reg[chosen_reg] <= in_size_reg;
                        ccost_reg[chosen_reg] <= cost_reg;
                    end
                end
                in_size_reg <= '0;
                scan_reg <= '0;
                near_f_reg <= 1'b0;
                free_f_reg <= 1'b0;
                for (int j = 0; j < Mc; j++) miss_reg[j] <= '0;
                result.cluster_index <= chosen_reg;
                result.distance <= create_reg ? -8'sd1 : $signed(8'(best_reg));
                result.opened_slot <= create_reg;
                result.center_replaced <= replace_reg;
                result.intensify_due <= !none_reg && (vol_up >= mv_eff);
            end
        end
    end

    // Done flags: the step counter has passed the list; pend covers the last read.
    logic [msca_pkg::SizeW-1:0] old_size;
    assign old_size = csize_reg[chosen_reg];

    always_comb begin
        sts.clear_done = (clr_cnt_reg == msca_pkg::NodeW'(msca_pkg::NodeCount - 1));
        sts.last_item = last_reg;
        sts.scan_done = (scan_reg == g_eff);
        sts.do_load = create_reg || replace_reg;
        sts.no_result = none_reg;
        sts.erase_done = (step_reg >= old_size);
        sts.write_done = (step_reg >= in_size_reg);
    end
endmodule

// ----- hdl/msca_ctrl.sv -----
`timescale 1ns / 1ps
module msca_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output msca_pkg::msca_cmd_t cmd,
    input  msca_pkg::msca_sts_t sts
);
    localparam logic [2:0] StClear  = 3'd0;
    localparam logic [2:0] StIdle   = 3'd1;
    localparam logic [2:0] StTally  = 3'd2;
    localparam logic [2:0] StDecide = 3'd3;
    localparam logic [2:0] StErase  = 3'd4;
    localparam logic [2:0] StWrite  = 3'd5;
    localparam logic [2:0] StFinish = 3'd6;
    localparam logic [2:0] StOut    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic ov_reg, ov_next;

    assign in_ready = (state_reg == StIdle);
    assign out_valid = ov_reg;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        unique case (state_reg)
            StClear: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done) state_next = StIdle;
            end
            StIdle: begin
                if (in_valid) begin
                    cmd.take_median = 1'b1;
                    state_next = StTally;
                end
            end
            StTally: begin
                cmd.tally = 1'b1;
                state_next = sts.last_item ? StDecide : StIdle;
            end
            StDecide: begin
                if (sts.scan_done) begin
                    cmd.decide = 1'b1;
                    state_next = StErase;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            StErase: begin
                if (!sts.do_load || sts.no_result) begin
                    state_next = StFinish;
                end else begin
                    cmd.erase_step = 1'b1;
                    if (sts.erase_done) state_next = StWrite;
                end
            end
            StWrite: begin
                cmd.write_step = 1'b1;
                if (sts.write_done) state_next = StFinish;
            end
            StFinish: begin
                if (!ov_reg || out_ready) begin
                    cmd.finish = 1'b1;
                    state_next = sts.no_result ? StIdle : StOut;
                end
            end
            StOut: begin
                ov_next = 1'b1;
                state_next = StIdle;
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StClear;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end
endmodule
